/* sv/mqe_pkg.sv */
// ----------------------------------------------------------------------------
// mqe_pkg
// Shared types and constants for the mailbox queue engine.
// ----------------------------------------------------------------------------
package mqe_pkg;

  localparam int unsigned MAILBOX_COUNT_DEF = 32;
  localparam int unsigned SLOTS_PER_BOX_DEF = 128;
  localparam int unsigned MESSAGE_WIDTH_DEF = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned CAP_W   = 8;
  localparam int unsigned MSG_W   = 32;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_SEND  = 3'd3,
    OP_RECV  = 3'd4,
    OP_COUNT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_META = 2'd1,
    ST_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic            init;
    logic            set;
    logic            clear;
    logic [ID_W-1:0] index;
  } alloc_cmd_t;

  typedef struct packed {
    logic            any;
    logic [ID_W-1:0] index;
  } free_info_t;

endpackage

/* sv/mqe_ram.sv */
// ----------------------------------------------------------------------------
// mqe_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mqe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mqe_alloc_table.sv */
// ----------------------------------------------------------------------------
// mqe_alloc_table
// Allocated flags of all mailboxes with lowest-free search.
// ----------------------------------------------------------------------------
module mqe_alloc_table
  import mqe_pkg::*;
#(
  parameter int unsigned MAILBOX_COUNT = MAILBOX_COUNT_DEF,
  localparam int unsigned IDW = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alloc_cmd_t               cmd_i,
  output logic [MAILBOX_COUNT-1:0] allocated_o,
  output free_info_t               free_o
);

  logic [MAILBOX_COUNT-1:0] alloc_q, alloc_d;
  logic [IDW-1:0]           idx;

  assign idx = cmd_i.index[IDW-1:0];

  always_comb begin
    alloc_d = alloc_q;
    if (cmd_i.init) begin
      alloc_d = '0;
    end else if (cmd_i.set) begin
      alloc_d[idx] = 1'b1;
    end else if (cmd_i.clear) begin
      alloc_d[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
    end else begin
      alloc_q <= alloc_d;
    end
  end

  // lowest-numbered free mailbox
  always_comb begin
    free_o.any   = ~&alloc_q;
    free_o.index = '0;
    for (int i = MAILBOX_COUNT - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_o.index = ID_W'(i);
      end
    end
  end

  assign allocated_o = alloc_q;

endmodule

/* sv/mailbox_queue_engine.sv */
// ----------------------------------------------------------------------------
// mailbox_queue_engine
// Table of mailboxes, each a bounded ring of message words in a shared
// message memory, with per-mailbox capacity, fill and head in a metadata RAM.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  operation, mailbox_id,
//                                                capacity, message
//   out      output     out_valid_o / out_stall_i status, value
//
// Each operation reads the metadata RAM at accept, then does the
// read-modify-write of metadata and at most one message RAM access; the result
// is loaded into the output register in the result step, which may accept
// the next word.
// Reset clears the allocated flags, not the RAMs; no clearing pass is needed.
// A stalled output holds the block in its result step until taken.
// ----------------------------------------------------------------------------
module mailbox_queue_engine
  import mqe_pkg::*;
#(
  parameter int unsigned MAILBOX_COUNT = MAILBOX_COUNT_DEF,
  parameter int unsigned SLOTS_PER_BOX = SLOTS_PER_BOX_DEF,
  parameter int unsigned MESSAGE_WIDTH = MESSAGE_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [OP_W-1:0]           operation_i,
  input  logic [ID_W-1:0]           mailbox_id_i,
  input  logic [CAP_W-1:0]          capacity_i,
  input  logic signed [MSG_W-1:0]   message_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      status_o,
  output logic signed [VALUE_W-1:0] value_o
);

  localparam int unsigned IDW    = (MAILBOX_COUNT > 1) ? $clog2(MAILBOX_COUNT) : 1;
  localparam int unsigned CW     = $clog2(SLOTS_PER_BOX + 1);
  localparam int unsigned HW     = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
  localparam int unsigned META_W = 2 * CW + HW;
  localparam int unsigned DEPTH  = MAILBOX_COUNT * SLOTS_PER_BOX;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW     = MESSAGE_WIDTH;

  state_e state_q, state_d;

  op_e          op_q;
  logic [ID_W-1:0]  id_q;
  logic [CAP_W-1:0] cap_q;
  logic [MW-1:0]    msg_q;

  logic               res_status_q, res_status_d;
  logic [VALUE_W-1:0] res_value_q, res_value_d;
  logic               use_msg_q, use_msg_d;

  logic               out_valid_q, out_valid_d;
  logic               out_status_q;
  logic [VALUE_W-1:0] out_value_q;

  logic in_accept, out_free, out_load, meta_step;

  logic [MAILBOX_COUNT-1:0] allocated;
  free_info_t               free_info;
  alloc_cmd_t               alloc_cmd;

  logic              meta_we;
  logic [IDW-1:0]    meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic [CW-1:0]     box_cap, box_fill;
  logic [HW-1:0]     box_head;

  logic          msg_we, msg_re;
  logic [AW-1:0] msg_addr;
  logic [MW-1:0] msg_rdata;

  logic signed [63:0]    msg_in_ext;
  logic signed [MW-1:0]  msg_rd_s;
  logic signed [63:0]    msg_rd_ext;

  logic [IDW-1:0] id_idx;
  logic           id_ok, usable;
  logic [CW:0]    slot_sum;
  logic [HW-1:0]  slot, head_next;
  logic [CW-1:0]  head_inc;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_o     = out_value_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_META;
      end
      ST_META: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = in_valid_i ? ST_META : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    meta_step  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_META: meta_step  = 1'b1;
      ST_RESP: begin
        in_stall_o = !out_free;
        out_load   = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // input word capture
  assign msg_in_ext = 64'(message_i);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= op_e'(operation_i);
      id_q  <= mailbox_id_i;
      cap_q <= capacity_i;
      msg_q <= msg_in_ext[MW-1:0];
    end
    if (meta_step) begin
      res_status_q <= res_status_d;
      res_value_q  <= res_value_d;
      use_msg_q    <= use_msg_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= use_msg_q ? msg_rd_ext[VALUE_W-1:0] : res_value_q;
    end
  end

  // metadata fields
  assign box_cap  = meta_rdata[META_W-1 -: CW];
  assign box_fill = meta_rdata[HW +: CW];
  assign box_head = meta_rdata[HW-1:0];

  assign id_idx = id_q[IDW-1:0];
  assign id_ok  = (9'(id_q) < 9'(MAILBOX_COUNT));
  assign usable = id_ok && allocated[id_idx];

  // ring arithmetic
  assign slot_sum  = (CW + 1)'(box_head) + (CW + 1)'(box_fill);
  assign slot      = (slot_sum >= (CW + 1)'(box_cap)) ?
                     HW'(slot_sum - (CW + 1)'(box_cap)) : HW'(slot_sum);
  assign head_inc  = CW'(box_head) + CW'(1);
  assign head_next = (head_inc == box_cap) ? '0 : HW'(head_inc);

  assign msg_rd_s   = msg_rdata;
  assign msg_rd_ext = 64'(msg_rd_s);

  // read-modify-write step
  always_comb begin
    res_status_d    = 1'b1;
    res_value_d     = '0;
    use_msg_d       = 1'b0;
    alloc_cmd       = '0;
    meta_we         = 1'b0;
    meta_waddr      = id_idx;
    meta_wdata      = meta_rdata;
    msg_we          = 1'b0;
    msg_re          = 1'b0;
    msg_addr        = AW'(AW'(id_idx) * AW'(SLOTS_PER_BOX)) + AW'(box_head);
    if (meta_step) begin
      unique case (op_q)
        OP_INIT: begin
          alloc_cmd.init = 1'b1;
          res_status_d   = 1'b0;
        end
        OP_ALLOC: begin
          if (11'(cap_q) <= 11'(SLOTS_PER_BOX) && free_info.any) begin
            alloc_cmd.set   = 1'b1;
            alloc_cmd.index = free_info.index;
            meta_we         = 1'b1;
            meta_waddr      = free_info.index[IDW-1:0];
            meta_wdata      = {CW'(cap_q), CW'(0), HW'(0)};
            res_status_d    = 1'b0;
            res_value_d     = VALUE_W'(free_info.index);
          end
        end
        OP_FREE: begin
          if (usable) begin
            alloc_cmd.clear = 1'b1;
            alloc_cmd.index = id_q;
            res_status_d    = 1'b0;
          end
        end
        OP_SEND: begin
          if (usable && box_fill < box_cap) begin
            msg_we       = 1'b1;
            msg_addr     = AW'(AW'(id_idx) * AW'(SLOTS_PER_BOX)) + AW'(slot);
            meta_we      = 1'b1;
            meta_wdata   = {box_cap, box_fill + CW'(1), box_head};
            res_status_d = 1'b0;
          end
        end
        OP_RECV: begin
          if (usable && box_fill != '0 && box_cap != '0) begin
            msg_re       = 1'b1;
            meta_we      = 1'b1;
            meta_wdata   = {box_cap, box_fill - CW'(1), head_next};
            use_msg_d    = 1'b1;
            res_status_d = 1'b0;
          end
        end
        OP_COUNT: begin
          if (usable) begin
            res_value_d  = VALUE_W'(box_fill);
            res_status_d = 1'b0;
          end
        end
        default: res_status_d = 1'b1;
      endcase
    end
  end

  mqe_alloc_table #(
    .MAILBOX_COUNT(MAILBOX_COUNT)
  ) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (alloc_cmd),
    .allocated_o(allocated),
    .free_o     (free_info)
  );

  mqe_ram #(
    .WIDTH(META_W),
    .DEPTH(MAILBOX_COUNT)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (meta_we),
    .waddr_i(meta_waddr),
    .wdata_i(meta_wdata),
    .re_i   (in_accept),
    .raddr_i(mailbox_id_i[IDW-1:0]),
    .rdata_o(meta_rdata)
  );

  mqe_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_msg_ram (
    .clk_i  (clk_i),
    .we_i   (msg_we),
    .waddr_i(msg_addr),
    .wdata_i(msg_q),
    .re_i   (msg_re),
    .raddr_i(msg_addr),
    .rdata_o(msg_rdata)
  );

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mailbox queue engine. A shadow of the mailbox
// table (allocation, capacity, fill, head and message memory) predicts one
// reply per accepted word; replies are checked in order as they leave the
// block. Stimulus runs a directed pass over the corner cases, a table
// exhaustion pass, mixed random traffic with random and back-to-back
// handshakes plus a long output hold, and a full-ring pass with wraparound.
// ----------------------------------------------------------------------------
module tb;
  import mqe_pkg::*;

  localparam int BOXES = MAILBOX_COUNT_DEF;
  localparam int SLOTS = SLOTS_PER_BOX_DEF;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value;
  } reply_t;

  class mailbox_shadow;
    bit           taken  [BOXES];
    bit [7:0]     cap_of [BOXES];
    bit [7:0]     fill_of[BOXES];
    bit [6:0]     head_of[BOXES];
    bit [MSG_W-1:0] words[BOXES*SLOTS];
    reply_t       replies_due[$];
    int           errors;

    function int pending();
      return replies_due.size();
    endfunction

    function void accept_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                            logic [CAP_W-1:0] cap, logic [MSG_W-1:0] msg);
      reply_t r;
      bit     usable;
      int     n;
      int     k;
      int     slot;
      r.status = 1'b1;
      r.value  = '0;
      n = int'(id);
      usable = (n < BOXES) && taken[n % BOXES];
      case (op)
        OP_INIT: begin
          foreach (taken[i]) taken[i] = 1'b0;
          r.status = 1'b0;
        end
        OP_ALLOC: begin
          if (cap <= SLOTS) begin
            for (k = 0; k < BOXES; k++) begin
              if (r.status && !taken[k]) begin
                taken[k]   = 1'b1;
                cap_of[k]  = cap;
                fill_of[k] = '0;
                head_of[k] = '0;
                r.status   = 1'b0;
                r.value    = k;
              end
            end
          end
        end
        OP_FREE: begin
          if (usable) begin
            taken[n] = 1'b0;
            r.status = 1'b0;
          end
        end
        OP_SEND: begin
          if (usable && fill_of[n] < cap_of[n]) begin
            slot = (int'(head_of[n]) + int'(fill_of[n])) % int'(cap_of[n]);
            words[n*SLOTS + slot] = msg;
            fill_of[n] = fill_of[n] + 8'd1;
            r.status = 1'b0;
          end
        end
        OP_RECV: begin
          if (usable && fill_of[n] != 0 && cap_of[n] != 0) begin
            r.value    = words[n*SLOTS + int'(head_of[n])];
            head_of[n] = 7'((int'(head_of[n]) + 1) % int'(cap_of[n]));
            fill_of[n] = fill_of[n] - 8'd1;
            r.status   = 1'b0;
          end
        end
        OP_COUNT: begin
          if (usable) begin
            r.value  = VALUE_W'(fill_of[n]);
            r.status = 1'b0;
          end
        end
        default: begin
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic status, logic [VALUE_W-1:0] value);
      reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: word with nothing expected, expected none actual status %0b value %0d",
                 $time, status, $signed(value));
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0b actual %0b", $time, want.status, status);
        errors++;
      end
      if (value !== want.value) begin
        $display("%0t: value expected %0d actual %0d", $time,
                 $signed(want.value), $signed(value));
        errors++;
      end
    endfunction
  endclass

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     operation  = '0;
  logic [ID_W-1:0]     mailbox_id = '0;
  logic [CAP_W-1:0]    capacity   = '0;
  logic [MSG_W-1:0]    message    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic                status;
  logic [VALUE_W-1:0]  value;

  mailbox_shadow book = new();
  bit send_eager = 1'b0;
  bit recv_eager = 1'b0;
  int hold_len   = 0;

  mailbox_queue_engine DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (operation),
    .mailbox_id_i (mailbox_id),
    .capacity_i   (capacity),
    .message_i    (message),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .value_o      (value)
  );

  always #2 clk_i = ~clk_i;

  function automatic int gap_for(bit eager);
    return eager ? 0 : $urandom_range(17, 0);
  endfunction

  // mostly a live mailbox, sometimes any in-range or out-of-range number
  function automatic logic [ID_W-1:0] pick_box();
    int live[$];
    int k;
    for (k = 0; k < BOXES; k++)
      if (book.taken[k]) live.push_back(k);
    if (live.size() == 0 || $urandom_range(9, 0) == 0)
      return ($urandom_range(4, 0) == 0) ? ID_W'($urandom_range(255, 0))
                                         : ID_W'($urandom_range(BOXES - 1, 0));
    return ID_W'(live[$urandom_range(live.size() - 1, 0)]);
  endfunction

  function automatic logic [CAP_W-1:0] pick_cap();
    case ($urandom_range(9, 0))
      7:       return CAP_W'(SLOTS);
      8:       return CAP_W'($urandom_range(255, SLOTS + 1));
      9:       return CAP_W'($urandom_range(255, 0));
      default: return CAP_W'($urandom_range(6, 0));
    endcase
  endfunction

  function automatic logic [MSG_W-1:0] pick_msg();
    if ($urandom_range(7, 0) != 0) return $urandom;
    case ($urandom_range(3, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // called at a rising edge; returns at the edge the word is taken
  task automatic put_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                          logic [CAP_W-1:0] cap, logic [MSG_W-1:0] msg);
    int idle;
    idle = gap_for(send_eager);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    mailbox_id <= id;
    capacity   <= cap;
    message    <= msg;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    book.accept_op(op, id, cap, msg);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (book.pending() != 0);
  endtask

  task automatic random_word();
    int               roll;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [CAP_W-1:0] cap;
    roll = $urandom_range(99, 0);
    id   = pick_box();
    cap  = CAP_W'($urandom_range(255, 0));
    if (roll < 2)       op = OP_INIT;
    else if (roll < 14) begin
      op  = OP_ALLOC;
      cap = pick_cap();
    end
    else if (roll < 22) op = OP_FREE;
    else if (roll < 55) op = OP_SEND;
    else if (roll < 85) op = OP_RECV;
    else if (roll < 93) op = OP_COUNT;
    else begin
      op = OP_W'($urandom_range(7, 0));
      id = ID_W'($urandom_range(255, 0));
    end
    put_word(op, id, cap, pick_msg());
  endtask

  always @(posedge clk_i)
    if (rst_ni && out_valid && !out_stall) book.check_reply(status, value);

  // output side stall pattern and long hold
  initial begin
    int idle;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        idle = gap_for(recv_eager);
        if (idle > 0) begin
          out_stall <= 1'b1;
          repeat (idle) @(posedge clk_i);
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner cases
    put_word(OP_COUNT, 0, 0, 0);
    put_word(OP_ALLOC, 8'hFF, 0, 0);
    put_word(OP_SEND, 0, 0, 32'h1234_5678);
    put_word(OP_RECV, 0, 0, 0);
    put_word(OP_ALLOC, 0, CAP_W'(SLOTS), 0);
    put_word(OP_ALLOC, 0, CAP_W'(SLOTS + 1), 0);
    put_word(OP_ALLOC, 0, 8'hFF, 0);
    put_word(OP_SEND, 1, 8'hFF, 32'h7FFF_FFFF);
    put_word(OP_SEND, 1, 0, 32'h8000_0000);
    put_word(OP_SEND, 1, 0, '0);
    put_word(OP_SEND, 1, 0, '1);
    put_word(OP_COUNT, 1, 0, 0);
    put_word(OP_RECV, 1, 0, 0);
    put_word(OP_RECV, 1, 0, 0);
    put_word(OP_ALLOC, 0, 1, 0);
    put_word(OP_SEND, 2, 0, 32'hA5A5_5A5A);
    put_word(OP_SEND, 2, 0, 32'h0F0F_F0F0);
    put_word(OP_RECV, 2, 0, 0);
    put_word(OP_RECV, 2, 0, 0);
    put_word(OP_SEND, ID_W'(BOXES), 0, '1);
    put_word(OP_RECV, 8'hFF, 0, 0);
    put_word(OP_SPARE_A, 1, 1, '1);
    put_word(OP_SPARE_B, 1, 1, '1);
    put_word(OP_FREE, 2, 0, 0);
    put_word(OP_FREE, 2, 0, 0);
    put_word(OP_INIT, 8'hFF, 8'hFF, '1);
    put_word(OP_COUNT, 1, 0, 0);
    drain();

    // fill the whole table, then one more
    for (k = 0; k <= BOXES; k++)
      put_word(OP_ALLOC, ID_W'($urandom_range(255, 0)), CAP_W'($urandom_range(6, 0)),
               pick_msg());
    put_word(OP_ALLOC, 0, CAP_W'(SLOTS + 1), 0);
    put_word(OP_FREE, ID_W'($urandom_range(BOXES - 1, 0)), 0, 0);
    put_word(OP_ALLOC, 0, CAP_W'($urandom_range(6, 1)), 0);

    for (k = 0; k < 20; k++) random_word();
    send_eager = 1'b1;
    recv_eager = 1'b1;
    for (k = 0; k < 15; k++) random_word();
    recv_eager = 1'b0;
    hold_len   = 90;
    for (k = 0; k < 20; k++) random_word();
    drain();
    send_eager = 1'b0;
    recv_eager = 1'b1;
    for (k = 0; k < 10; k++) random_word();
    drain();

    // one full ring with a moved head, so the slots wrap
    recv_eager = 1'b0;
    put_word(OP_INIT, 0, 0, 0);
    put_word(OP_ALLOC, 0, CAP_W'(SLOTS), 0);
    for (k = 0; k < 5; k++) put_word(OP_SEND, 0, 0, pick_msg());
    for (k = 0; k < 5; k++) put_word(OP_RECV, 0, 0, 0);
    for (k = 0; k <= SLOTS; k++) put_word(OP_SEND, 0, 0, pick_msg());
    put_word(OP_COUNT, 0, 0, 0);
    for (k = 0; k <= SLOTS; k++) put_word(OP_RECV, 0, 0, 0);
    put_word(OP_COUNT, 0, 0, 0);

    drain();
    repeat (20) @(posedge clk_i);
    if (book.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
